### rtl/svl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted value list package
// Shared widths, the cell command struct and the controller state type.
// ----------------------------------------------------------------------------
package svl_pkg;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 5;
    localparam int CNT_W     = 6;
    localparam int MAX_CELLS = 32;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ADD,
        CELL_DEL,
        CELL_ROT
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } svl_state_t;

endpackage

### rtl/svl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted value list cell
// Holds one list entry and updates it from its neighbors for an insert, a
// delete or one step of the output rotation.
// ----------------------------------------------------------------------------
module svl_cell
(
    input  logic                              clk,
    input  svl_pkg::cell_ctl_t                ctl,
    input  logic                              occupied,
    input  logic                              tail,
    input  logic signed [svl_pkg::DATA_W-1:0] head_value,
    input  logic signed [svl_pkg::DATA_W-1:0] left_value,
    input  logic                              left_greater,
    input  logic signed [svl_pkg::DATA_W-1:0] right_value,
    input  logic                              match_in,
    output logic signed [svl_pkg::DATA_W-1:0] value,
    output logic                              greater,
    output logic                              match_out
);

    logic signed [svl_pkg::DATA_W-1:0] value_reg;
    logic signed [svl_pkg::DATA_W-1:0] value_next;

    assign value     = value_reg;
    assign greater   = !occupied || (value_reg > ctl.value);
    assign match_out = match_in || (occupied && (value_reg == ctl.value));

    always_comb
    begin
        case (ctl.op)
            svl_pkg::CELL_ADD:
            begin
                if (greater)
                    value_next = left_greater ? left_value : ctl.value;
                else
                    value_next = value_reg;
            end
            svl_pkg::CELL_DEL:
            begin
                value_next = match_out ? right_value : value_reg;
            end
            svl_pkg::CELL_ROT:
            begin
                value_next = tail ? head_value : right_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

### rtl/sorted_value_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted value list core
// Bounded multiset of signed Q16.16 values kept in ascending order in a row
// of cells. Every operation is followed by a read-out of the whole list.
// ----------------------------------------------------------------------------
// Usage: an input word (action, value) is taken when in_valid is high and
// in_stall is low. Action 0 inserts the value after any equal copies; action
// 1 removes the lowest-ranked equal copy, or sets not_found if none exists.
// An insert into a full list is dropped and flags dropped_full.
// The cells update at the edge that takes the input word, and the first
// output word is valid in the next cycle. The list is then read out in
// ascending order, one word per accepted output cycle, by rotating the
// occupied cells toward cell 0; after n words it is back in order. An empty
// list gives one word with list_empty set. is_last marks the final word.
// An item therefore gives max(n, 1) output words, where n is the count after
// the operation, and the core takes no new word until its last word is
// accepted; in_stall is high during the read-out. When out_stall is
// high the output word and the cells hold. Reset empties the list
// and returns to idle at once; entry contents are never cleared.
// ----------------------------------------------------------------------------
module sorted_value_list_core
#(
    parameter int CAPACITY = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic signed [svl_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [svl_pkg::DATA_W-1:0] sorted_value,
    output logic [svl_pkg::POS_W-1:0]         position,
    output logic                              is_last,
    output logic                              list_empty,
    output logic                              not_found,
    output logic                              dropped_full,
    output logic [svl_pkg::CNT_W-1:0]         entry_count
);

    localparam int NCELL = (CAPACITY < svl_pkg::MAX_CELLS) ? CAPACITY : svl_pkg::MAX_CELLS;
    localparam int IW    = $clog2(NCELL);
    localparam int CW    = $clog2(NCELL + 1);

    svl_pkg::svl_state_t state_reg;
    svl_pkg::svl_state_t state_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [IW-1:0]       pos_reg;
    logic [IW-1:0]       pos_next;
    logic                miss_reg;
    logic                miss_next;
    logic                full_reg;
    logic                full_next;

    svl_pkg::cell_ctl_t                ctl;
    logic signed [svl_pkg::DATA_W-1:0] cell_value [NCELL];
    logic                              cell_greater [NCELL];
    logic                              cell_match [NCELL];
    logic                              in_accept;
    logic                              out_accept;
    logic                              last_word;
    logic                              found;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;
    assign found      = cell_match[NCELL-1];
    assign last_word  = (count_reg == '0) || (CW'(pos_reg) == count_reg - CW'(1));

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            logic signed [svl_pkg::DATA_W-1:0] left_v;
            logic                              left_g;
            logic signed [svl_pkg::DATA_W-1:0] right_v;
            logic                              m_in;

            if (gi == 0)
            begin : g_first
                assign left_v = '0;
                assign left_g = 1'b0;
                assign m_in   = 1'b0;
            end
            else
            begin : g_inner
                assign left_v = cell_value[gi-1];
                assign left_g = cell_greater[gi-1];
                assign m_in   = cell_match[gi-1];
            end

            if (gi == NCELL - 1)
            begin : g_end
                assign right_v = cell_value[gi];
            end
            else
            begin : g_mid
                assign right_v = cell_value[gi+1];
            end

            svl_cell u_cell
            (
                .clk          (clk),
                .ctl          (ctl),
                .occupied     (CW'(gi) < count_reg),
                .tail         (CW'(gi) == count_reg - CW'(1)),
                .head_value   (cell_value[0]),
                .left_value   (left_v),
                .left_greater (left_g),
                .right_value  (right_v),
                .match_in     (m_in),
                .value        (cell_value[gi]),
                .greater      (cell_greater[gi]),
                .match_out    (cell_match[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        miss_next  = miss_reg;
        full_next  = full_reg;
        ctl.op     = svl_pkg::CELL_HOLD;
        ctl.value  = value;
        in_stall   = 1'b1;
        out_valid  = 1'b0;

        case (state_reg)
            svl_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = svl_pkg::ST_EMIT;
                    pos_next   = '0;
                    miss_next  = 1'b0;
                    full_next  = 1'b0;
                    if (!action)
                    begin
                        if (count_reg == CW'(NCELL))
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            ctl.op     = svl_pkg::CELL_ADD;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        if (found)
                        begin
                            ctl.op     = svl_pkg::CELL_DEL;
                            count_next = count_reg - CW'(1);
                        end
                        else
                        begin
                            miss_next = 1'b1;
                        end
                    end
                end
            end
            svl_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (count_reg != '0)
                        ctl.op = svl_pkg::CELL_ROT;
                    if (last_word)
                        state_next = svl_pkg::ST_IDLE;
                    else
                        pos_next = pos_reg + IW'(1);
                end
            end
            default:
            begin
                state_next = svl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= svl_pkg::ST_IDLE;
            count_reg <= '0;
            pos_reg   <= '0;
            miss_reg  <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            miss_reg  <= miss_next;
            full_reg  <= full_next;
        end
    end

    assign sorted_value = (count_reg == '0) ? '0 : cell_value[0];
    assign position     = svl_pkg::POS_W'(pos_reg);
    assign is_last      = last_word;
    assign list_empty   = (count_reg == '0);
    assign not_found    = miss_reg;
    assign dropped_full = full_reg;
    assign entry_count  = svl_pkg::CNT_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(NCELL))
        else $error("entry count above capacity");

    a_accept_emits: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == svl_pkg::ST_EMIT))
        else $error("accepted word did not start a read-out");

    a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && is_last) |=> (state_reg == svl_pkg::ST_IDLE))
        else $error("read-out continued after last word");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (count_reg != '0)) |-> (CW'(pos_reg) < count_reg))
        else $error("read-out position beyond list");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dropped_full) |-> (count_reg == CW'(NCELL)))
        else $error("dropped word flagged with list not full");

endmodule

### tb/sv/sorted_value_list_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted value list core testbench
// Sends add and delete words to the core with random idle cycles on both
// sides and checks every read-out word against a behavioral copy of the list.
// A directed table covers the extremes, duplicates, misses and the empty
// list. Random phases then fill the list past capacity, drain it below
// empty and mix both, with one long output hold-off and drained pauses.
// ----------------------------------------------------------------------------
module sorted_value_list_core_tb;

    localparam int DATA_W          = svl_pkg::DATA_W;
    localparam int POS_W           = svl_pkg::POS_W;
    localparam int CNT_W           = svl_pkg::CNT_W;
    localparam int LIST_CAP        = svl_pkg::MAX_CELLS;
    localparam int RANDOM_ITEMS    = 340;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_DEL = 1'b1;

    localparam logic signed [DATA_W-1:0] Q_MIN  = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] Q_NEG1 = 32'shFFFF_FFFF;

    typedef enum logic [1:0] {
        PH_FILL,
        PH_DRAIN,
        PH_MIX
    } phase_t;

    typedef struct {
        logic signed [DATA_W-1:0] sorted_value;
        logic [POS_W-1:0]         position;
        logic                     is_last;
        logic                     list_empty;
        logic                     not_found;
        logic                     dropped_full;
        logic [CNT_W-1:0]         entry_count;
    } list_word_t;

    typedef struct {
        logic                     act;
        logic signed [DATA_W-1:0] val;
        bit                       typed;
        logic signed [DATA_W-1:0] exp_value;
        logic                     exp_empty;
        logic                     exp_miss;
        logic [CNT_W-1:0]         exp_count;
    } table_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     action;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] sorted_value;
    logic [POS_W-1:0]         position;
    logic                     is_last;
    logic                     list_empty;
    logic                     not_found;
    logic                     dropped_full;
    logic [CNT_W-1:0]         entry_count;

    logic signed [DATA_W-1:0] list_copy [LIST_CAP];
    int                       list_count = 0;
    list_word_t               pending_words [$];
    table_row_t               direct_rows [$];
    int                       error_count = 0;
    bit                       burst_phase = 1'b0;
    bit                       hold_off_req = 1'b0;

    sorted_value_list_core #(
        .CAPACITY(LIST_CAP)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sorted_value(sorted_value),
        .position(position),
        .is_last(is_last),
        .list_empty(list_empty),
        .not_found(not_found),
        .dropped_full(dropped_full),
        .entry_count(entry_count)
    );

    always #5 clk = ~clk;

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_phase || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Applies one word to the list copy and queues the read-out it causes.
    function automatic int apply_list_op(input logic act, input logic signed [DATA_W-1:0] val);
        int         slot;
        bit         miss;
        bit         full;
        list_word_t w;
        miss = 1'b0;
        full = 1'b0;
        if (act == ACT_ADD)
        begin
            if (list_count >= LIST_CAP)
            begin
                full = 1'b1;
            end
            else
            begin
                slot = 0;
                while (slot < list_count && list_copy[slot] <= val)
                    slot++;
                for (int i = list_count; i > slot; i--)
                    list_copy[i] = list_copy[i-1];
                list_copy[slot] = val;
                list_count++;
            end
        end
        else
        begin
            slot = 0;
            while (slot < list_count && list_copy[slot] != val)
                slot++;
            if (slot == list_count)
            begin
                miss = 1'b1;
            end
            else
            begin
                for (int i = slot; i < list_count - 1; i++)
                    list_copy[i] = list_copy[i+1];
                list_count--;
            end
        end
        w.not_found    = miss;
        w.dropped_full = full;
        w.entry_count  = CNT_W'(list_count);
        if (list_count == 0)
        begin
            w.sorted_value = '0;
            w.position     = '0;
            w.is_last      = 1'b1;
            w.list_empty   = 1'b1;
            pending_words  = {pending_words, w};
            return 1;
        end
        for (int i = 0; i < list_count; i++)
        begin
            w.sorted_value = list_copy[i];
            w.position     = POS_W'(i);
            w.is_last      = (i == list_count - 1);
            w.list_empty   = 1'b0;
            pending_words  = {pending_words, w};
        end
        return list_count;
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin
        list_word_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_words.size() == 0)
            begin
                note_error($sformatf("unexpected word value=%0d position=%0d",
                                     sorted_value, position));
            end
            else
            begin
                want = pending_words.pop_front();
                if (want.sorted_value !== sorted_value || want.position !== position
                    || want.is_last !== is_last || want.list_empty !== list_empty
                    || want.not_found !== not_found || want.dropped_full !== dropped_full
                    || want.entry_count !== entry_count)
                    note_error($sformatf({"mismatch exp value=%0d pos=%0d last=%b empty=%b ",
                                          "nf=%b full=%b count=%0d, got value=%0d pos=%0d ",
                                          "last=%b empty=%b nf=%b full=%b count=%0d"},
                                         want.sorted_value, want.position, want.is_last,
                                         want.list_empty, want.not_found, want.dropped_full,
                                         want.entry_count, sorted_value, position, is_last,
                                         list_empty, not_found, dropped_full, entry_count));
            end
        end
    end

    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                n = idle_gap();
                out_stall <= (n != 0);
                if (n > 1)
                    repeat (n - 1) @(negedge clk);
            end
        end
    end

    // Called at a falling edge; returns at a falling edge with the word taken.
    task automatic offer_word(input logic act, input logic signed [DATA_W-1:0] val,
                              input bit typed, input list_word_t typed_word);
        int gap;
        int n;
        in_valid <= 1'b1;
        action   <= act;
        value    <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n = apply_list_op(act, val);
        if (typed)
        begin
            repeat (n) void'(pending_words.pop_back());
            pending_words = {pending_words, typed_word};
        end
        gap = idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_words.size() != 0)
            @(negedge clk);
    endtask

    task automatic add_row(input logic act, input logic signed [DATA_W-1:0] val,
                           input bit typed, input logic signed [DATA_W-1:0] exp_value,
                           input logic exp_empty, input logic exp_miss,
                           input logic [CNT_W-1:0] exp_count);
        table_row_t row;
        row.act       = act;
        row.val       = val;
        row.typed     = typed;
        row.exp_value = exp_value;
        row.exp_empty = exp_empty;
        row.exp_miss  = exp_miss;
        row.exp_count = exp_count;
        direct_rows   = {direct_rows, row};
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int k;
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            k = int'($urandom_range(0, 12)) - 6;
            return k * 32'sh0000_8000;
        end
        if (r < 40)
        begin
            case ($urandom_range(0, 4))
                0: return Q_MIN;
                1: return Q_MAX;
                2: return '0;
                3: return Q_NEG1;
                default: return 32'sh0000_0001;
            endcase
        end
        return $urandom;
    endfunction

    task automatic random_word(input phase_t phase, output logic act,
                               output logic signed [DATA_W-1:0] val);
        int add_pct;
        case (phase)
            PH_FILL:  add_pct = 90;
            PH_DRAIN: add_pct = 15;
            default:  add_pct = 50;
        endcase
        if ($urandom_range(0, 99) < add_pct)
        begin
            act = ACT_ADD;
            val = pick_value();
        end
        else
        begin
            act = ACT_DEL;
            if (list_count > 0 && $urandom_range(0, 99) < 80)
                val = list_copy[$urandom_range(0, list_count - 1)];
            else
                val = pick_value();
        end
    endtask

    initial
    begin
        list_word_t                w;
        phase_t                    phase;
        int                        phase_len;
        int                        phase_idx;
        int                        sent;
        logic                      act;
        logic signed [DATA_W-1:0]  val;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        action   = ACT_ADD;
        value    = '0;

        add_row(ACT_DEL, '0,     1'b1, '0,    1'b1, 1'b1, '0);
        add_row(ACT_ADD, Q_MIN,  1'b1, Q_MIN, 1'b0, 1'b0, CNT_W'(1));
        add_row(ACT_DEL, Q_MIN,  1'b1, '0,    1'b1, 1'b0, '0);
        add_row(ACT_ADD, Q_MAX,  1'b1, Q_MAX, 1'b0, 1'b0, CNT_W'(1));
        add_row(ACT_DEL, '0,     1'b1, Q_MAX, 1'b0, 1'b1, CNT_W'(1));
        add_row(ACT_ADD, Q_MIN,  1'b0, '0, 1'b0, 1'b0, '0);
        add_row(ACT_ADD, '0,     1'b0, '0, 1'b0, 1'b0, '0);
        add_row(ACT_ADD, Q_ONE,  1'b0, '0, 1'b0, 1'b0, '0);
        add_row(ACT_ADD, Q_ONE,  1'b0, '0, 1'b0, 1'b0, '0);
        add_row(ACT_ADD, Q_NEG1, 1'b0, '0, 1'b0, 1'b0, '0);
        add_row(ACT_ADD, 32'sh0001_8000, 1'b0, '0, 1'b0, 1'b0, '0);
        add_row(ACT_DEL, Q_ONE,  1'b0, '0, 1'b0, 1'b0, '0);
        add_row(ACT_DEL, 32'sh0002_0000, 1'b0, '0, 1'b0, 1'b0, '0);
        add_row(ACT_ADD, Q_MAX,  1'b0, '0, 1'b0, 1'b0, '0);
        add_row(ACT_DEL, Q_MAX,  1'b0, '0, 1'b0, 1'b0, '0);
        add_row(ACT_DEL, Q_MIN,  1'b0, '0, 1'b0, 1'b0, '0);
        add_row(ACT_ADD, 32'sh7FFF_0000, 1'b0, '0, 1'b0, 1'b0, '0);
        add_row(ACT_DEL, 32'sh0000_0001, 1'b0, '0, 1'b0, 1'b0, '0);
        add_row(ACT_DEL, Q_NEG1, 1'b0, '0, 1'b0, 1'b0, '0);
        add_row(ACT_ADD, 32'sh5555_5555, 1'b0, '0, 1'b0, 1'b0, '0);
        add_row(ACT_ADD, 32'shAAAA_AAAA, 1'b0, '0, 1'b0, 1'b0, '0);
        add_row(ACT_DEL, 32'sh5555_5555, 1'b0, '0, 1'b0, 1'b0, '0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (direct_rows[i])
        begin
            w.sorted_value = direct_rows[i].exp_value;
            w.position     = '0;
            w.is_last      = 1'b1;
            w.list_empty   = direct_rows[i].exp_empty;
            w.not_found    = direct_rows[i].exp_miss;
            w.dropped_full = 1'b0;
            w.entry_count  = direct_rows[i].exp_count;
            offer_word(direct_rows[i].act, direct_rows[i].val, direct_rows[i].typed, w);
        end
        pause_until_drained();

        phase_idx = 0;
        sent      = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase_idx == 0)
                phase = PH_FILL;
            else
                phase = phase_t'($urandom_range(0, 2));
            burst_phase = ($urandom_range(0, 3) == 0);
            if (phase_idx == 2)
            begin
                burst_phase  = 1'b0;
                hold_off_req = 1'b1;
            end
            if (phase_idx == 3 || $urandom_range(0, 3) == 0)
                pause_until_drained();
            case (phase)
                PH_FILL:  phase_len = LIST_CAP - list_count + $urandom_range(1, 4);
                PH_DRAIN: phase_len = list_count + $urandom_range(1, 3);
                default:  phase_len = $urandom_range(15, 40);
            endcase
            for (int k = 0; k < phase_len; k++)
            begin
                random_word(phase, act, val);
                offer_word(act, val, 1'b0, w);
                sent++;
            end
            phase_idx++;
        end

        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("[sorted_value_list_core] OK");
        else
            $display("[sorted_value_list_core] ERROR");
        $finish;
    end

    initial
    begin
        #25_000_000;
        $display("[sorted_value_list_core] ERROR");
        $finish;
    end

endmodule
